// ----- design/positional_insert_delete_list_top_assert.svh -----
// assertion macros for the positional insert/delete list
`ifndef POSITIONAL_INSERT_DELETE_LIST_TOP_ASSERT_SVH
`define POSITIONAL_INSERT_DELETE_LIST_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// checked at every rising edge outside reset
`define PIDL_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pidl check failed");

// checked at every rising edge, reset included
`define PIDL_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("pidl check failed");

`else

`define PIDL_ASSERT(label, clk, rst, prop)
`define PIDL_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ----- design/pidl_pkg.sv -----
package pidl_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int KIND_W   = 2;
  localparam int POS_W    = 5;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // operation codes on the command channel
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2
  } status_e;

  // what every cell does in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2
  } cell_op_e;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [POS_W-1:0]   position;
    logic [VALUE_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    status_e            status;
    logic [VALUE_W-1:0] read_value;
    logic [COUNT_W-1:0] entry_count;
  } rsp_t;

endpackage

// ----- design/positional_insert_delete_list_top.sv -----
// Ordered list of up to DEPTH words held in a row of cells, one word per cell.
// Commands: insert at a position (a position past the end appends), remove at
// a position, read at a position. Every command transfer gives exactly one
// response carrying a status, the word read (zero unless a read succeeded)
// and the entry count after the command. The whole row shifts at once,
// so a command completes in the cycle it is transferred and its response is
// registered for the cycle after. One command is taken per cycle as long as the
// response side keeps up; cmd_stall rises only while a response is held
// waiting (rsp_valid high with rsp_stall high). No clearing pass after reset:
// entries are only ever read below the count.
module positional_insert_delete_list_top #(
  parameter int DEPTH      = pidl_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = pidl_pkg::DATA_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  pidl_pkg::cmd_t cmd,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output pidl_pkg::rsp_t rsp
);
  import pidl_pkg::*;

  // count runs 0..DEPTH
  localparam int CNT_W = $clog2(DEPTH + 1);
  // width for comparing the 5-bit position against the count
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  logic                  take;
  logic                  full;
  logic                  pos_below;
  logic                  pos_upto;
  logic                  rd_en;
  cell_op_e              cell_op;
  logic [CNT_W-1:0]      cell_pos;
  status_e               status;
  logic [DATA_WIDTH-1:0] ins_value;
  logic [DATA_WIDTH-1:0] rd_word;

  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DATA_WIDTH-1:0] cell_rd   [DEPTH];

  // the response register parts the two sides
  assign cmd_stall = rsp_valid && rsp_stall;
  assign take      = cmd_valid && !cmd_stall;

  assign full      = (count == FULL_COUNT);
  assign pos_below = (CMP_W'(cmd.position) <  CMP_W'(count));
  assign pos_upto  = (CMP_W'(cmd.position) <= CMP_W'(count));
  assign ins_value = DATA_WIDTH'(cmd.value);

  // decode one command into the row's shift control
  always_comb begin
    cell_op    = CELL_HOLD;
    cell_pos   = CNT_W'(cmd.position);
    status     = ST_BADPOS;
    count_next = count;
    rd_en      = 1'b0;
    if (take) begin
      unique case (cmd.kind)
        KIND_INSERT: begin
          if (full) begin
            status = ST_FULL;
          end else begin
            cell_op    = CELL_INSERT;
            // past the end means append at the count
            cell_pos   = pos_upto ? CNT_W'(cmd.position) : count;
            count_next = count + 1'b1;
            status     = ST_DONE;
          end
        end
        KIND_REMOVE: begin
          if (pos_below) begin
            cell_op    = CELL_REMOVE;
            count_next = count - 1'b1;
            status     = ST_DONE;
          end
        end
        KIND_READ: begin
          if (pos_below) begin
            rd_en  = 1'b1;
            status = ST_DONE;
          end
        end
        default: status = ST_BADPOS;  // unused kind changes nothing
      endcase
    end
  end

  // row of cells: each takes its left neighbour on insert, right on remove
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_in;
    logic [DATA_WIDTH-1:0] right_in;

    if (i == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_mid_l
      assign left_in = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_mid_r
      assign right_in = cell_data[i+1];
    end

    pidl_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W),
      .INDEX      (i)
    ) u_cell (
      .clk        (clk),
      .op         (cell_op),
      .pos        (cell_pos),
      .ins_value  (ins_value),
      .from_left  (left_in),
      .from_right (right_in),
      .data       (cell_data[i]),
      .rd_part    (cell_rd[i])
    );
  end

  // only the addressed cell drives non-zero, so an or over the row selects it
  always_comb begin
    rd_word = '0;
    for (int k = 0; k < DEPTH; k++) begin
      rd_word = rd_word | cell_rd[k];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (take) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // response payload, loaded on each command transfer
  always_ff @(posedge clk) begin
    if (take) begin
      rsp.status      <= status;
      rsp.read_value  <= rd_en ? VALUE_W'(rd_word) : '0;
      rsp.entry_count <= COUNT_W'(count_next);
    end
  end

  // checks

  `include "positional_insert_delete_list_top_assert.svh"

  `PIDL_ASSERT(a_count_bound, clk, rst, count <= FULL_COUNT)
  `PIDL_ASSERT(a_insert_grows, clk, rst, cell_op == CELL_INSERT |=> count == $past(count) + 1'b1)
  `PIDL_ASSERT(a_remove_shrinks, clk, rst, cell_op == CELL_REMOVE |=> count == $past(count) - 1'b1)
  `PIDL_ASSERT(a_full_status, clk, rst, (rsp_valid && rsp.status == ST_FULL) |-> full)
  `PIDL_ASSERT_ALWAYS(a_stall_only_holding, clk, cmd_stall |-> rsp_valid)

endmodule

// ----- design/pidl_cell.sv -----
module pidl_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int CNT_W      = 5,
  parameter int INDEX      = 0
) (
  input  logic                   clk,
  input  pidl_pkg::cell_op_e     op,
  input  logic [CNT_W-1:0]       pos,
  input  logic [DATA_WIDTH-1:0]  ins_value,
  input  logic [DATA_WIDTH-1:0]  from_left,
  input  logic [DATA_WIDTH-1:0]  from_right,
  output logic [DATA_WIDTH-1:0]  data,
  output logic [DATA_WIDTH-1:0]  rd_part
);
  import pidl_pkg::*;

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

  logic [DATA_WIDTH-1:0] data_next;

  always_comb begin
    data_next = data;
    unique case (op)
      CELL_INSERT: begin
        if (pos == MY_IDX) begin
          data_next = ins_value;
        end else if (MY_IDX > pos) begin
          data_next = from_left;
        end
      end
      CELL_REMOVE: begin
        if (MY_IDX >= pos) begin
          data_next = from_right;
        end
      end
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  // only the addressed cell offers its word to the read tree
  assign rd_part = data & {DATA_WIDTH{pos == MY_IDX}};

endmodule

// ----- bench/pidl_checker.sv -----
module pidl_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  logic           cmd_stall,
  input  pidl_pkg::cmd_t cmd,
  input  logic           rsp_valid,
  input  logic           rsp_stall,
  input  pidl_pkg::rsp_t rsp,
  output int             errors,
  output int             pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import pidl_pkg::*;

  localparam int LIST_DEPTH = DEPTH_DEF;

  // shadow copy of the list
  logic [VALUE_W-1:0] list_words [LIST_DEPTH];
  int                 list_len;
  rsp_t               due_rsps [$];

  task automatic report_mismatch(string msg);
    $display("list_chk %0t ns: %s", $time, msg);
    errors++;
  endtask

  // carries out one command on the shadow list and gives its response
  function automatic rsp_t apply_list_op(cmd_t c);
    rsp_t r;
    int   slot;
    r.status     = ST_BADPOS;
    r.read_value = '0;
    case (c.kind)
      KIND_INSERT: begin
        if (list_len >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // past the end means append
          slot = (int'(c.position) > list_len) ? list_len : int'(c.position);
          for (int i = list_len; i > slot; i--) list_words[i] = list_words[i-1];
          list_words[slot] = c.value;
          list_len++;
          r.status = ST_DONE;
        end
      end
      KIND_REMOVE: begin
        if (int'(c.position) < list_len) begin
          for (int i = int'(c.position); i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
          r.status = ST_DONE;
        end
      end
      KIND_READ: begin
        if (int'(c.position) < list_len) begin
          r.read_value = list_words[int'(c.position)];
          r.status     = ST_DONE;
        end
      end
      default: ;  // unused kind: nothing changes
    endcase
    r.entry_count = COUNT_W'(list_len);
    return r;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      list_len = 0;
      errors   = 0;
      due_rsps.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (due_rsps.size() == 0) begin
          report_mismatch($sformatf("response transfer with none due (status %0d)",
                                    rsp.status));
        end else begin
          want = due_rsps.pop_front();
          if (rsp.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", rsp.status, want.status));
          if (rsp.read_value !== want.read_value)
            report_mismatch($sformatf("read_value got %h want %h",
                                      rsp.read_value, want.read_value));
          if (rsp.entry_count !== want.entry_count)
            report_mismatch($sformatf("entry_count got %0d want %0d",
                                      rsp.entry_count, want.entry_count));
        end
      end
      if (cmd_valid && !cmd_stall) due_rsps.push_back(apply_list_op(cmd));
    end
    pending = due_rsps.size();
  end

endmodule

// ----- bench/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pidl_pkg::*;

  localparam int RANDOM_ITEMS = 750;
  localparam int IDLE_LIMIT   = 2000;  // cycles with no transfer on either side
  localparam int HOLD_CYCLES  = 60;    // long back-pressure stretch on the response side
  localparam int HOLD_AFTER   = 200;   // command transfers before the long hold starts
  localparam int DRAIN_CYCLES = 8;

  // the kind code the block does not define
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // command mix of a random phase
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_e;

  // response-side stall pattern of a segment
  typedef enum int {STALL_NONE, STALL_COIN, STALL_EVERY_THIRD, STALL_HEAVY} stall_e;

  logic clk = 1'b0;
  logic rst;
  logic cmd_valid;
  logic cmd_stall;
  cmd_t cmd;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  int errors;
  int pending;
  int cmds_sent   = 0;
  int idle_cycles = 0;
  bit hold_active = 1'b0;
  bit hold_done   = 1'b0;

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  positional_insert_delete_list_top DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // predicts every response and compares, hands back the error count
  pidl_checker list_chk (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .errors    (errors),
    .pending   (pending)
  );

  function automatic cmd_t pack_cmd(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos,
                                    logic [VALUE_W-1:0] value);
    cmd_t c;
    c.kind     = kind;
    c.position = pos;
    c.value    = value;
    return c;
  endfunction

  // random command; the mix steers the list towards full, empty or neither
  function automatic cmd_t random_item(mix_e mix);
    int                 roll;
    logic [KIND_W-1:0]  kind;
    logic [POS_W-1:0]   pos;
    logic [VALUE_W-1:0] value;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  kind = roll < 70 ? KIND_INSERT : roll < 85 ? KIND_REMOVE :
                        roll < 96 ? KIND_READ : KIND_UNUSED;
      MIX_DRAIN: kind = roll < 15 ? KIND_INSERT : roll < 75 ? KIND_REMOVE :
                        roll < 96 ? KIND_READ : KIND_UNUSED;
      default:   kind = roll < 35 ? KIND_INSERT : roll < 65 ? KIND_REMOVE :
                        roll < 96 ? KIND_READ : KIND_UNUSED;
    endcase
    // mostly positions the list can hold, some near the head, some far out of range
    roll = $urandom_range(0, 99);
    if (roll < 65)      pos = POS_W'($urandom_range(0, 16));
    else if (roll < 85) pos = POS_W'($urandom_range(0, 2));
    else                pos = POS_W'($urandom_range(0, 31));
    roll = $urandom_range(0, 99);
    if (roll < 5)       value = '0;
    else if (roll < 10) value = '1;
    else                value = $urandom;
    return pack_cmd(kind, pos, value);
  endfunction

  // called at a falling edge; holds the command until its transfer, returns at a falling edge
  task automatic offer_cmd(cmd_t c);
    cmd_valid <= 1'b1;
    cmd       <= c;
    do @(posedge clk); while (cmd_stall);
    cmds_sent++;
    @(negedge clk);
  endtask

  // command side: reset, directed cases, then random phases in bursts
  initial begin
    int   directed_sent;
    int   burst_left;
    int   phase_left;
    int   gap;
    mix_e mix;
    rst       = 1'b1;
    cmd_valid = 1'b0;
    cmd       = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty list: read and remove are refused, so is the unused kind
    offer_cmd(pack_cmd(KIND_READ,   5'd0, 32'h0));
    offer_cmd(pack_cmd(KIND_REMOVE, 5'd0, 32'h0));
    offer_cmd(pack_cmd(KIND_UNUSED, 5'd3, 32'hFFFF_FFFF));
    // insert far past the end appends; then at the head and in the middle
    offer_cmd(pack_cmd(KIND_INSERT, 5'd31, 32'hFFFF_FFFF));
    offer_cmd(pack_cmd(KIND_INSERT, 5'd0,  32'h0));
    offer_cmd(pack_cmd(KIND_INSERT, 5'd1,  32'hA5A5_A5A5));
    offer_cmd(pack_cmd(KIND_READ,   5'd0,  32'h0));
    offer_cmd(pack_cmd(KIND_READ,   5'd31, 32'h0));
    // remove the last entry
    offer_cmd(pack_cmd(KIND_REMOVE, 5'd2,  32'h0));
    // fill to capacity, then one insert too many
    repeat (14) offer_cmd(pack_cmd(KIND_INSERT, POS_W'($urandom_range(0, 16)), $urandom));
    offer_cmd(pack_cmd(KIND_INSERT, 5'd4,  $urandom));
    offer_cmd(pack_cmd(KIND_READ,   5'd15, 32'h0));
    offer_cmd(pack_cmd(KIND_REMOVE, 5'd15, 32'h0));
    directed_sent = cmds_sent;

    phase_left = 0;
    while (cmds_sent < directed_sent + RANDOM_ITEMS) begin
      if (phase_left == 0) begin
        mix        = mix_e'($urandom_range(0, 2));
        phase_left = $urandom_range(30, 60);
      end
      burst_left = $urandom_range(1, 20);
      while (burst_left > 0 && phase_left > 0) begin
        offer_cmd(random_item(mix));
        burst_left--;
        phase_left--;
      end
      // no gaps while the response side is held off, so the block fills up
      gap = (hold_active || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        cmd_valid <= 1'b0;
        cmd       <= pack_cmd(KIND_W'($urandom_range(0, 3)), POS_W'($urandom_range(0, 31)),
                              $urandom);
        repeat (gap) @(negedge clk);
      end
    end
    cmd_valid <= 1'b0;

    // let every response arrive, then watch a little longer for strays
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // response side: stall in segments of differing pattern, with one long hold
  initial begin
    int     seg_len;
    stall_e pattern;
    rsp_stall = 1'b0;
    forever begin
      if (!hold_done && cmds_sent >= HOLD_AFTER) begin
        hold_active = 1'b1;
        @(negedge clk);
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_active = 1'b0;
        hold_done   = 1'b1;
      end
      pattern = stall_e'($urandom_range(0, 3));
      seg_len = $urandom_range(10, 80);
      for (int k = 0; k < seg_len; k++) begin
        @(negedge clk);
        case (pattern)
          STALL_NONE:        rsp_stall <= 1'b0;
          STALL_COIN:        rsp_stall <= 1'($urandom_range(0, 1));
          STALL_EVERY_THIRD: rsp_stall <= (k % 3 == 0);
          default:           rsp_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // watchdog: too long without any transfer means the block has hung
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
